### rtl/core/sdtq_pkg.sv
package sdtq_pkg;

	localparam int SDTQ_SLOTS = 16;
	localparam int SDTQ_ID_W  = 4;
	localparam int SDTQ_DL_W  = 32;

	localparam logic OP_TICK     = 1'b0;
	localparam logic OP_SCHEDULE = 1'b1;

	localparam logic STATUS_EXPIRED  = 1'b0;
	localparam logic STATUS_REJECTED = 1'b1;

	typedef struct packed {
		logic                 valid;
		logic [SDTQ_ID_W-1:0] id;
		logic [SDTQ_DL_W-1:0] deadline;
	} entry_t;

	typedef struct packed {
		logic   insert;
		logic   pop;
		entry_t new_entry;
	} cell_ctrl_t;

	// True when a - b, taken as a signed wrapping difference, is negative.
	function automatic logic wrap_before(input logic [SDTQ_DL_W-1:0] a,
		input logic [SDTQ_DL_W-1:0] b);
		logic [SDTQ_DL_W-1:0] diff;
		diff = a - b;
		return diff[SDTQ_DL_W-1];
	endfunction

endpackage

### rtl/core/sdtq_if.sv
interface sdtq_req_if;
	import sdtq_pkg::*;

	logic                 valid;
	logic                 ready;
	logic                 operation;
	logic [SDTQ_ID_W-1:0] timer_id;
	logic [SDTQ_DL_W-1:0] deadline;

	modport source (output valid, operation, timer_id, deadline, input ready);
	modport sink (input valid, operation, timer_id, deadline, output ready);
	modport monitor (input valid, ready, operation, timer_id, deadline);
endinterface

interface sdtq_rsp_if;
	import sdtq_pkg::*;

	logic                 valid;
	logic                 ready;
	logic [SDTQ_ID_W-1:0] fired_id;
	logic                 status;
	logic                 last;

	modport source (output valid, fired_id, status, last, input ready);
	modport sink (input valid, fired_id, status, last, output ready);
	modport monitor (input valid, ready, fired_id, status, last);
endinterface

### rtl/core/sdtq_cell.sv
module sdtq_cell (
	input  logic                clk,
	input  logic                arst_n,
	input  sdtq_pkg::cell_ctrl_t ctrl,
	input  sdtq_pkg::entry_t    prev_entry,
	input  sdtq_pkg::entry_t    next_entry,
	input  logic                taken_in,
	output logic                taken_out,
	output sdtq_pkg::entry_t    entry
);
	import sdtq_pkg::*;

	logic                 valid_q;
	logic [SDTQ_ID_W-1:0] id_q;
	logic [SDTQ_DL_W-1:0] deadline_q;
	logic                 match;
	entry_t               entry_d;

	assign entry = '{valid: valid_q, id: id_q, deadline: deadline_q};

	// The new deadline belongs here if this slot is free or holds a later deadline.
	assign match     = !valid_q || wrap_before(ctrl.new_entry.deadline, deadline_q);
	assign taken_out = taken_in || match;

	always_comb begin
		entry_d = entry;
		if (ctrl.insert) begin
			if (taken_in) begin
				entry_d = prev_entry;
			end else if (match) begin
				entry_d       = ctrl.new_entry;
				entry_d.valid = 1'b1;
			end
		end else if (ctrl.pop) begin
			entry_d = next_entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else begin
			valid_q <= entry_d.valid;
		end
	end

	always_ff @(posedge clk) begin
		id_q       <= entry_d.id;
		deadline_q <= entry_d.deadline;
	end

endmodule

### rtl/core/sorted_deadline_timer_queue_core.sv
// Channel  Role    Payload
// req      sink    operation, timer_id, deadline
// rsp      source  fired_id, status, last
//
// An item is taken while the block is idle; after that the block loads one
// result per cycle while rsp does not stall, popping the head cell of the
// chain for each expired timer; a rejection is loaded without a pop.
// Reset clears the tick count and the slot valid bits at once; no clearing pass.
// A stall on rsp holds the result in the output register and stops the drain;
// req stays low until the last result of the item has been loaded.
module sorted_deadline_timer_queue_core #(
	parameter int TIMER_SLOTS = sdtq_pkg::SDTQ_SLOTS
) (
	input  logic          clk,
	input  logic          arst_n,
	sdtq_req_if.sink      req,
	sdtq_rsp_if.source    rsp
);
	import sdtq_pkg::*;

	localparam logic ST_IDLE  = 1'b0;
	localparam logic ST_DRAIN = 1'b1;

	logic                 state_q;
	logic [SDTQ_DL_W-1:0] tick_q;
	logic                 rej_pend_q;
	logic [SDTQ_ID_W-1:0] rej_id_q;
	logic                 out_valid_q;
	logic [SDTQ_ID_W-1:0] out_id_q;
	logic                 out_status_q;
	logic                 out_last_q;

	entry_t     slot_entry [TIMER_SLOTS];
	entry_t     prev_link  [TIMER_SLOTS];
	entry_t     next_link  [TIMER_SLOTS];
	logic       taken      [TIMER_SLOTS+1];
	cell_ctrl_t ctrl;

	logic accept;
	logic full;
	logic head_exp;
	logic next_exp;
	logic out_free;
	logic load;
	logic load_last;

	assign req.ready = (state_q == ST_IDLE);
	assign accept    = req.valid && req.ready;
	assign full      = slot_entry[TIMER_SLOTS-1].valid;

	assign head_exp = slot_entry[0].valid && !wrap_before(tick_q, slot_entry[0].deadline);
	assign next_exp = slot_entry[1].valid && !wrap_before(tick_q, slot_entry[1].deadline);

	assign out_free  = !out_valid_q || rsp.ready;
	assign load      = (state_q == ST_DRAIN) && out_free && (rej_pend_q || head_exp);
	assign load_last = rej_pend_q ? !head_exp : !next_exp;

	assign ctrl.insert    = accept && (req.operation == OP_SCHEDULE) && !full;
	assign ctrl.pop       = load && !rej_pend_q;
	assign ctrl.new_entry = '{valid: 1'b1, id: req.timer_id, deadline: req.deadline};

	assign taken[0] = 1'b0;

	for (genvar i = 0; i < TIMER_SLOTS; i++) begin : g_slot
		if (i == 0) begin : g_first
			assign prev_link[i] = '0;
		end else begin : g_mid
			assign prev_link[i] = slot_entry[i-1];
		end
		if (i == TIMER_SLOTS - 1) begin : g_last
			assign next_link[i] = '0;
		end else begin : g_inner
			assign next_link[i] = slot_entry[i+1];
		end

		sdtq_cell u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.ctrl       (ctrl),
			.prev_entry (prev_link[i]),
			.next_entry (next_link[i]),
			.taken_in   (taken[i]),
			.taken_out  (taken[i+1]),
			.entry      (slot_entry[i])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			tick_q      <= '0;
			rej_pend_q  <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				state_q    <= ST_DRAIN;
				rej_pend_q <= (req.operation == OP_SCHEDULE) && full;
				if (req.operation == OP_TICK) begin
					tick_q <= tick_q + 1'b1;
				end
			end else if (state_q == ST_DRAIN) begin
				if (load) begin
					rej_pend_q <= 1'b0;
					if (load_last) begin
						state_q <= ST_IDLE;
					end
				end else if (!rej_pend_q && !head_exp) begin
					state_q <= ST_IDLE;
				end
			end

			if (load) begin
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			rej_id_q <= req.timer_id;
		end
		if (load) begin
			out_id_q     <= rej_pend_q ? rej_id_q : slot_entry[0].id;
			out_status_q <= rej_pend_q ? STATUS_REJECTED : STATUS_EXPIRED;
			out_last_q   <= load_last;
		end
	end

	assign rsp.valid    = out_valid_q;
	assign rsp.fired_id = out_id_q;
	assign rsp.status   = out_status_q;
	assign rsp.last     = out_last_q;

endmodule

### rtl/core/sdtq_checker.sv
module sdtq_checker (
	input logic clk,
	input logic arst_n,
	input logic req_valid,
	input logic req_ready,
	input logic rsp_valid,
	input logic rsp_ready,
	input logic rsp_last
);

	// A held result waits until it is taken.
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid)
		else $error("result dropped before it was taken");

	// Every accepted item is followed by at least one drain cycle.
	a_req_busy: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready |=> !req_ready)
		else $error("input taken again without a drain cycle");

	// While a result that is not the last one waits, the item is still draining.
	a_mid_busy: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_last |-> !req_ready)
		else $error("input ready while results of the item remain");

endmodule

bind sorted_deadline_timer_queue_core sdtq_checker u_sdtq_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.req_valid (req.valid),
	.req_ready (req.ready),
	.rsp_valid (rsp.valid),
	.rsp_ready (rsp.ready),
	.rsp_last  (rsp.last)
);
